// ----- hw/rtl/rrd_pkg.sv -----
package rrd_pkg;

  localparam int MAX_ARGS    = 255;
  localparam int ARG_W       = $clog2(MAX_ARGS + 1);
  localparam int LEN_BITS    = 32;
  localparam int CFG_W       = 24;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] MAX_BYTES_RST = CFG_W'(65536);

  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ANUM,
    PH_ALF,
    PH_BHDR,
    PH_BNUM,
    PH_BLF,
    PH_DATA,
    PH_TR1,
    PH_TR2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FRAME,
    KIND_CMD,
    KIND_ARG
  } token_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_BAD_NUMBER,
    ERR_NOT_DOLLAR,
    ERR_INLINE,
    ERR_DUP_ARRAY,
    ERR_TOO_MANY,
    ERR_TOO_BIG
  } err_code_t;

  // classified request byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_star;
    logic       is_dollar;
    logic       is_space;
  } rrd_byte_t;

endpackage

// ----- hw/rtl/rrd_front.sv -----
module rrd_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              fifo_full,
  output logic              push,
  output rrd_pkg::rrd_byte_t push_data
);
  import rrd_pkg::*;

  logic [7:0] diff;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;
  assign diff     = in_data_byte - CH_ZERO;

  always_comb begin
    push_data           = '0;
    push_data.data      = in_data_byte;
    push_data.digit     = diff[3:0];
    push_data.is_digit  = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);
    push_data.is_cr     = (in_data_byte == CH_CR);
    push_data.is_lf     = (in_data_byte == CH_LF);
    push_data.is_star   = (in_data_byte == CH_STAR);
    push_data.is_dollar = (in_data_byte == CH_DOLLAR);
    push_data.is_space  = (in_data_byte == CH_SPACE);
  end

endmodule

// ----- hw/rtl/rrd_fifo.sv -----
module rrd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rrd_pkg::rrd_byte_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output rrd_pkg::rrd_byte_t head
);
  import rrd_pkg::*;

  rrd_byte_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/rrd_back.sv -----
module rrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [23:0]        cfg_max_request_bytes,
  input  logic               fifo_empty,
  input  rrd_pkg::rrd_byte_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte_out,
  output logic [1:0]         out_token_kind,
  output logic [7:0]         out_arg_number,
  output logic               out_token_first,
  output logic               out_token_last,
  output logic               out_request_done,
  output logic [2:0]         out_error_code
);
  import rrd_pkg::*;

  logic [CFG_W-1:0]    max_bytes_r;
  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] accum_r, accum_nxt;
  logic [ARG_W-1:0]    args_exp_r, args_exp_nxt;
  logic [ARG_W-1:0]    args_rcv_r, args_rcv_nxt;
  logic [LEN_BITS-1:0] remain_r, remain_nxt;
  logic [CFG_W-1:0]    req_bytes_r, req_bytes_nxt;
  logic                have_cmd_r, have_cmd_nxt;

  logic                out_valid_r;
  logic [7:0]          byte_r;
  token_kind_t         kind_r, kind_nxt;
  logic [ARG_W-1:0]    argn_r, argn_nxt;
  logic                first_r, first_nxt;
  logic                last_r, last_nxt;
  logic                done_r, done_nxt;
  err_code_t           err_r, err_nxt;

  logic [LEN_BITS+3:0] acc_ext;
  logic                acc_ovf;
  logic [LEN_BITS-1:0] remain_dec;
  logic [ARG_W:0]      args_inc;

  assign pop = !fifo_empty && (!out_valid_r || !out_stall);

  // accum * 10 + digit, with overflow out of the length width
  assign acc_ext = ((LEN_BITS+4)'(accum_r) << 3) + ((LEN_BITS+4)'(accum_r) << 1)
                   + (LEN_BITS+4)'(head.digit);
  assign acc_ovf = |acc_ext[LEN_BITS+3:LEN_BITS];
  assign remain_dec = (remain_r != '0) ? remain_r - 1'b1 : remain_r;
  assign args_inc = have_cmd_r ? {1'b0, args_rcv_r} + 1'b1 : {1'b0, args_rcv_r};

  always_comb begin
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    args_exp_nxt  = args_exp_r;
    args_rcv_nxt  = args_rcv_r;
    remain_nxt    = remain_r;
    req_bytes_nxt = req_bytes_r;
    have_cmd_nxt  = have_cmd_r;
    kind_nxt      = KIND_FRAME;
    argn_nxt      = '0;
    first_nxt     = 1'b0;
    last_nxt      = 1'b0;
    done_nxt      = 1'b0;
    err_nxt       = ERR_NONE;
    if (phase_r == PH_IDLE && head.is_space) begin
      // leading space between requests
    end else if (req_bytes_r >= max_bytes_r) begin
      err_nxt = ERR_TOO_BIG;
    end else begin
      req_bytes_nxt = req_bytes_r + 1'b1;
      case (phase_r)
        PH_IDLE: begin
          if (head.is_star) begin
            accum_nxt = '0;
            phase_nxt = PH_ANUM;
          end else if (head.is_dollar) begin
            err_nxt = ERR_INLINE;
          end else begin
            err_nxt = ERR_NOT_DOLLAR;
          end
        end
        PH_ANUM, PH_BNUM: begin
          if (head.is_cr) begin
            phase_nxt = (phase_r == PH_ANUM) ? PH_ALF : PH_BLF;
          end else if (!head.is_digit || acc_ovf) begin
            err_nxt = ERR_BAD_NUMBER;
          end else begin
            accum_nxt = acc_ext[LEN_BITS-1:0];
          end
        end
        PH_ALF: begin
          if (!head.is_lf || accum_r == '0) begin
            err_nxt = ERR_BAD_NUMBER;
          end else if (accum_r > LEN_BITS'(MAX_ARGS + 1)) begin
            err_nxt = ERR_TOO_MANY;
          end else begin
            args_exp_nxt = ARG_W'(accum_r - 1'b1);
            args_rcv_nxt = '0;
            have_cmd_nxt = 1'b0;
            phase_nxt    = PH_BHDR;
          end
        end
        PH_BHDR: begin
          if (head.is_dollar) begin
            accum_nxt = '0;
            phase_nxt = PH_BNUM;
          end else if (head.is_star) begin
            err_nxt = ERR_DUP_ARRAY;
          end else if (!head.is_space) begin
            err_nxt = ERR_NOT_DOLLAR;
          end
        end
        PH_BLF: begin
          if (!head.is_lf || accum_r == '0) begin
            err_nxt = ERR_BAD_NUMBER;
          end else begin
            remain_nxt = accum_r;
            phase_nxt  = PH_DATA;
          end
        end
        PH_DATA: begin
          kind_nxt   = have_cmd_r ? KIND_ARG : KIND_CMD;
          argn_nxt   = args_rcv_r;
          first_nxt  = (remain_r == accum_r);
          last_nxt   = (remain_r <= LEN_BITS'(1));
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            phase_nxt = PH_TR1;
          end
        end
        PH_TR1: begin
          phase_nxt = PH_TR2;
        end
        PH_TR2: begin
          have_cmd_nxt = 1'b1;
          args_rcv_nxt = args_inc[ARG_W-1:0];
          if (args_inc >= {1'b0, args_exp_r}) begin
            done_nxt = 1'b1;
          end else begin
            phase_nxt = PH_BHDR;
          end
        end
        default: begin
          err_nxt = ERR_BAD_NUMBER;
        end
      endcase
    end
    if (err_nxt != ERR_NONE) begin
      kind_nxt  = KIND_FRAME;
      argn_nxt  = '0;
      first_nxt = 1'b0;
      last_nxt  = 1'b0;
      done_nxt  = 1'b0;
    end
    // end of request, good or bad
    if (err_nxt != ERR_NONE || done_nxt) begin
      phase_nxt     = PH_IDLE;
      accum_nxt     = '0;
      args_exp_nxt  = '0;
      args_rcv_nxt  = '0;
      remain_nxt    = '0;
      req_bytes_nxt = '0;
      have_cmd_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
    end else if (cfg_write_en) begin
      max_bytes_r <= cfg_max_request_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      accum_r     <= '0;
      args_exp_r  <= '0;
      args_rcv_r  <= '0;
      remain_r    <= '0;
      req_bytes_r <= '0;
      have_cmd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        accum_r     <= accum_nxt;
        args_exp_r  <= args_exp_nxt;
        args_rcv_r  <= args_rcv_nxt;
        remain_r    <= remain_nxt;
        req_bytes_r <= req_bytes_nxt;
        have_cmd_r  <= have_cmd_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r  <= head.data;
      kind_r  <= kind_nxt;
      argn_r  <= argn_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      done_r  <= done_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = byte_r;
  assign out_token_kind   = kind_r;
  assign out_arg_number   = 8'(argn_r);
  assign out_token_first  = first_r;
  assign out_token_last   = last_r;
  assign out_request_done = done_r;
  assign out_error_code   = err_r;

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && err_nxt != ERR_NONE |=> phase_r == PH_IDLE && req_bytes_r == '0)
    else $error("request state not cleared after error");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r != ERR_NONE |-> kind_r == KIND_FRAME && !done_r && !first_r)
    else $error("error transaction carries token flags");

  a_flags_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (first_r || last_r) |-> kind_r != KIND_FRAME)
    else $error("first or last flag on a framing byte");

  a_args_bound: assert property (@(posedge clk) disable iff (!rst_n)
    args_rcv_r <= args_exp_r)
    else $error("argument count beyond expected");

  a_data_remain: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != '0)
    else $error("data phase with no bytes left");

endmodule

// ----- hw/rtl/resp_request_deframer.sv -----
// Byte-serial deframer for requests framed as an array of bulk strings ('*' count CR LF,
// then per element '$' length CR LF data and two trailer bytes). Every accepted byte
// yields exactly one result transaction that echoes the byte and tags it as framing,
// command data or argument data, with first/last marks, the argument index, a
// request-done flag on the final trailer byte, or an error code; any error drops the
// request and the parser returns to idle. One byte is taken per clock, sustained while
// the output does not stall. An accepted byte is written into the two-entry queue after
// the byte classifier, and the parser then takes it from that queue into the output
// register. in_stall rises only when that queue is full, which happens only while the
// output is stalled. cfg_max_request_bytes (reset 65536) limits a request's length in
// bytes, counted from its '*'; write it only while no transaction is in flight.
module resp_request_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [23:0] cfg_max_request_bytes,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic [1:0]  out_token_kind,
  output logic [7:0]  out_arg_number,
  output logic        out_token_first,
  output logic        out_token_last,
  output logic        out_request_done,
  output logic [2:0]  out_error_code
);
  import rrd_pkg::*;

  logic      fifo_full;
  logic      fifo_empty;
  logic      push;
  logic      pop;
  rrd_byte_t push_data;
  rrd_byte_t head;

  rrd_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_data    (push_data)
  );

  rrd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .empty     (fifo_empty),
    .head      (head)
  );

  rrd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_max_request_bytes (cfg_max_request_bytes),
    .fifo_empty            (fifo_empty),
    .head                  (head),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte_out          (out_byte_out),
    .out_token_kind        (out_token_kind),
    .out_arg_number        (out_arg_number),
    .out_token_first       (out_token_first),
    .out_token_last        (out_token_last),
    .out_request_done      (out_request_done),
    .out_error_code        (out_error_code)
  );

endmodule

// ----- tb/tb_resp_request_deframer.sv -----
module tb_resp_request_deframer;
  import rrd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BYTES = 193;

  typedef struct packed {
    logic [7:0]  echo;
    token_kind_t kind;
    logic [7:0]  arg_num;
    logic        first;
    logic        last;
    logic        done;
    err_code_t   err;
  } tag_t;

  class deframe_sb;
    tag_t        tags_due[$];
    int          fails;
    logic [23:0] byte_limit;
    phase_t      ph;
    logic [31:0] accum;
    logic [7:0]  args_exp;
    logic [7:0]  args_rcv;
    logic [31:0] remaining;
    logic [23:0] req_count;
    logic        have_cmd;

    function new();
      fails = 0;
      byte_limit = MAX_BYTES_RST;
      drop_request();
    endfunction

    function void drop_request();
      ph = PH_IDLE;
      accum = '0;
      args_exp = '0;
      args_rcv = '0;
      remaining = '0;
      req_count = '0;
      have_cmd = 1'b0;
    endfunction

    function tag_t tag_for_byte(logic [7:0] c);
      tag_t t;
      logic is_dig;
      logic [63:0] v;
      t = '0;
      t.echo = c;
      t.kind = KIND_FRAME;
      t.err = ERR_NONE;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      if (ph == PH_IDLE && c == CH_SPACE) begin
        // leading space is dropped
      end else if ({8'd0, req_count} + 32'd1 > {8'd0, byte_limit}) begin
        t.err = ERR_TOO_BIG;
      end else begin
        req_count = req_count + 24'd1;
        case (ph)
          PH_IDLE: begin
            if (c == CH_STAR) begin
              accum = '0;
              ph = PH_ANUM;
            end else if (c == CH_DOLLAR) begin
              t.err = ERR_INLINE;
            end else begin
              t.err = ERR_NOT_DOLLAR;
            end
          end
          PH_ANUM, PH_BNUM: begin
            if (c == CH_CR) begin
              ph = (ph == PH_ANUM) ? PH_ALF : PH_BLF;
            end else begin
              v = {32'd0, accum} * 64'd10 + {56'd0, c} - 64'd48;
              if (!is_dig || v > (64'd1 << LEN_BITS) - 64'd1) t.err = ERR_BAD_NUMBER;
              else accum = v[31:0];
            end
          end
          PH_ALF: begin
            if (c != CH_LF || accum == 0) begin
              t.err = ERR_BAD_NUMBER;
            end else if (accum - 32'd1 > 32'(MAX_ARGS)) begin
              t.err = ERR_TOO_MANY;
            end else begin
              args_exp = 8'(accum - 32'd1);
              args_rcv = '0;
              have_cmd = 1'b0;
              ph = PH_BHDR;
            end
          end
          PH_BHDR: begin
            if (c == CH_DOLLAR) begin
              accum = '0;
              ph = PH_BNUM;
            end else if (c == CH_STAR) begin
              t.err = ERR_DUP_ARRAY;
            end else if (c != CH_SPACE) begin
              t.err = ERR_NOT_DOLLAR;
            end
          end
          PH_BLF: begin
            if (c != CH_LF || accum == 0) begin
              t.err = ERR_BAD_NUMBER;
            end else begin
              remaining = accum;
              ph = PH_DATA;
            end
          end
          PH_DATA: begin
            t.kind = have_cmd ? KIND_ARG : KIND_CMD;
            t.arg_num = args_rcv;
            t.first = (remaining == accum);
            t.last = (remaining <= 32'd1);
            if (remaining > 0) remaining = remaining - 32'd1;
            if (remaining == 0) ph = PH_TR1;
          end
          PH_TR1: ph = PH_TR2;
          PH_TR2: begin
            if (!have_cmd) have_cmd = 1'b1;
            else args_rcv = args_rcv + 8'd1;
            if (args_rcv >= args_exp) begin
              t.done = 1'b1;
              drop_request();
            end else begin
              ph = PH_BHDR;
            end
          end
          default: t.err = ERR_BAD_NUMBER;
        endcase
      end
      if (t.err != ERR_NONE) begin
        t.kind = KIND_FRAME;
        t.arg_num = '0;
        t.first = 1'b0;
        t.last = 1'b0;
        t.done = 1'b0;
        drop_request();
      end
      return t;
    endfunction

    function void note_byte(logic [7:0] c);
      tags_due.push_back(tag_for_byte(c));
    endfunction

    function void check_tag(tag_t got);
      tag_t want;
      if (tags_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result transaction, byte %02h", got.echo);
        return;
      end
      want = tags_due.pop_front();
      if (got.echo !== want.echo || got.kind !== want.kind || got.arg_num !== want.arg_num ||
          got.first !== want.first || got.last !== want.last || got.done !== want.done ||
          got.err !== want.err) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch expected: byte %02h kind %0d arg %0d first %0b last %0b done %0b err %0d",
                   want.echo, want.kind, want.arg_num, want.first, want.last, want.done,
                   want.err);
          $display("         actual:   byte %02h kind %0d arg %0d first %0b last %0b done %0b err %0d",
                   got.echo, got.kind, got.arg_num, got.first, got.last, got.done, got.err);
        end
      end
    endfunction

    function int due_count();
      return tags_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic [23:0] cfg_max_request_bytes = MAX_BYTES_RST;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte_out;
  logic [1:0]  out_token_kind;
  logic [7:0]  out_arg_number;
  logic        out_token_first;
  logic        out_token_last;
  logic        out_request_done;
  logic [2:0]  out_error_code;

  deframe_sb   sb;
  logic [7:0]  frame[$];
  int unsigned sent = 0;
  int          burst_left = 0;
  int          gap_max = 4;
  int          cycle_count = 0;
  int          stall_mode = 0;
  logic [7:0]  stall_cnt = 8'd0;

  resp_request_deframer u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_max_request_bytes (cfg_max_request_bytes),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_byte_out          (out_byte_out),
    .out_token_kind        (out_token_kind),
    .out_arg_number        (out_arg_number),
    .out_token_first       (out_token_first),
    .out_token_last        (out_token_last),
    .out_request_done      (out_request_done),
    .out_error_code        (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL resp_request_deframer");
      $finish;
    end
  end

  // receiver stall pattern, mode drawn anew at random each time stall_cnt runs down to zero
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= 8'd200;
    end else begin
      stall_cnt <= stall_cnt - 8'd1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cnt[3:0] < 4'd10);
    endcase
  end

  always @(posedge clk) begin
    tag_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.echo = out_byte_out;
      seen.kind = token_kind_t'(out_token_kind);
      seen.arg_num = out_arg_number;
      seen.first = out_token_first;
      seen.last = out_token_last;
      seen.done = out_request_done;
      seen.err = err_code_t'(out_error_code);
      sb.check_tag(seen);
    end
  end

  function automatic logic [7:0] odd_byte();
    case ($urandom_range(0, 9))
      0: return CH_STAR;
      1: return CH_DOLLAR;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_SPACE;
      5: return CH_ZERO;
      6: return CH_NINE;
      7: return 8'h2f;
      8: return 8'h3a;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic put_crlf();
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
  endtask

  task automatic put_number(input int unsigned n);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) frame.push_back(CH_ZERO);
    put_text($sformatf("%0d", n));
  endtask

  // one byte transaction, with a random gap before each burst
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
    frame.delete();
  endtask

  task automatic write_limit(input logic [23:0] v);
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_max_request_bytes <= v;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.byte_limit = v;
    burst_left = 0;
  endtask

  initial begin
    logic [23:0] limit_plan[7];
    int unsigned goal, nstr, maxlen, len, pick, pos;
    sb = new();
    limit_plan = '{24'hFFFFFF, 24'd1, 24'd30, 24'd65536, 24'd12, 24'd100, 24'hFFFFFF};
    limit_plan[5] = 24'($urandom_range(40, 300));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_text(" $");
    put_text("q");
    put_text("*0");
    put_crlf();
    put_text("*1");
    put_crlf();
    put_text(" $1");
    put_crlf();
    frame.push_back(8'hff);
    frame.push_back(8'h00);
    frame.push_back(8'h80);
    put_text("*257");
    put_crlf();
    put_text("*2");
    put_crlf();
    put_text("*");
    put_text("*1");
    put_crlf();
    put_text("$0");
    put_crlf();
    put_text("*4294967296");
    send_frame();

    for (int p = 0; p < 7; p++) begin
      write_limit(limit_plan[p]);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      goal = sent + PHASE_BYTES;
      while (sent < goal) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          repeat ($urandom_range(1, 4)) frame.push_back(odd_byte());
        end else begin
          nstr = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
          maxlen = ($urandom_range(0, 9) == 0) ? 40 : 8;
          if ($urandom_range(0, 7) == 0) frame.push_back(CH_SPACE);
          frame.push_back(CH_STAR);
          put_number(nstr);
          put_crlf();
          for (int i = 0; i < nstr; i++) begin
            if ($urandom_range(0, 9) == 0) frame.push_back(CH_SPACE);
            frame.push_back(CH_DOLLAR);
            len = $urandom_range(1, maxlen);
            put_number(len);
            put_crlf();
            repeat (len + 2) frame.push_back(8'($urandom));
          end
          // broken request: one byte replaced or the tail cut off
          if (pick < 5) begin
            pos = $urandom_range(0, frame.size() - 1);
            if ($urandom_range(0, 1) == 0) frame[pos] = odd_byte();
            else while (frame.size() > pos + 1) frame.delete(frame.size() - 1);
          end
        end
        send_frame();
      end
    end

    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) $display("PASS resp_request_deframer");
    else $display("FAIL resp_request_deframer");
    $finish;
  end

endmodule
